### rtl/vertex_weld_dedup_table_top_assert.svh
// assertion macros shared by the vertex weld checker
`ifndef VERTEX_WELD_DEDUP_TABLE_TOP_ASSERT_SVH
`define VERTEX_WELD_DEDUP_TABLE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define VWD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/vwd_pkg.sv
// shared types and constants of the vertex weld dedup table
`default_nettype none
package vwd_pkg;

  localparam int MaxVertices = 4096;
  localparam int HashSlots   = 8192;
  localparam int KeyLen      = 9;
  localparam int IdxW        = $clog2(MaxVertices);
  localparam int CntW        = IdxW + 1;
  localparam int SlotW       = $clog2(HashSlots);

  localparam logic [1:0] CmdVertex = 2'd0;
  localparam logic [1:0] CmdFace   = 2'd1;
  localparam logic [1:0] CmdClear  = 2'd2;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusFull   = 2'd1;
  localparam logic [1:0] StatusUnseen = 2'd2;

  localparam logic CfgHasNormals = 1'b0;
  localparam logic CfgHasUv      = 1'b1;

  typedef logic [KeyLen-1:0][31:0] key_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] norm_x;
    logic [31:0] norm_y;
    logic [31:0] norm_z;
    logic [31:0] tex_u;
    logic [31:0] tex_v;
    logic [31:0] tex_w;
    logic [11:0] face_index;
  } in_t;

  typedef struct packed {
    logic [11:0] vertex_index;
    logic        is_new;
    logic [1:0]  status;
  } out_t;

endpackage
`default_nettype wire

### rtl/vertex_weld_dedup_table_top.sv
// vertex weld dedup table: hash lookup, key store and remap store
//
//   port group        dir  transfer when
//   start/in_i        in   start high, busy low at clk edge
//   done_o/out_o      out  done_o high, one cycle, always taken
//   cfg_we_i/idx/data in   cfg_we_i high at clk edge
//
// vertex: start the hash unit and fold the nine key words (StHash); for each
// probe read the slot (StProbe, StSlot), store a new key on an empty slot, else
// read and compare the stored key (StCmp), moving to the next slot on mismatch.
// face, full remap store, unseen face, undefined command: StFace or StFin.
// clear and reset sweep all 8192 slots, one per cycle; busy stays high.
// results cannot be stalled; a new command may start in the done cycle.
`default_nettype none
module vertex_weld_dedup_table_top import vwd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_i,
  input  wire logic cfg_we_i,
  input  wire logic cfg_idx_i,
  input  wire logic cfg_wdata_i,
  output logic      done_o,
  output out_t      out_o
);

  typedef enum logic [2:0] {
    StClr, StIdle, StHash, StProbe, StSlot, StCmp, StFace, StFin
  } state_e;

  state_e            state_q;
  logic [SlotW-1:0]  clr_cnt_q;
  logic              clr_report_q;
  logic [SlotW-1:0]  probe_q;
  logic [CntW-1:0]   uc_q;
  logic [CntW-1:0]   vs_q;
  logic [IdxW-1:0]   hit_idx_q;
  key_t              key_q;
  key_t              key_d;
  logic              hash_start_q;
  logic              nrm_q;
  logic              uv_q;
  logic              done_q;
  out_t              out_q;
  out_t              res_q;

  logic              hash_done;
  logic [SlotW-1:0]  hash_val;
  logic              slot_we;
  logic [SlotW-1:0]  slot_waddr;
  logic [SlotW-1:0]  slot_wdata;
  logic [SlotW-1:0]  slot_rdata;
  logic              key_we;
  key_t              key_rdata;
  logic [IdxW-1:0]   key_raddr;
  logic              remap_we;
  logic [IdxW-1:0]   remap_wdata;
  logic [IdxW-1:0]   remap_rdata;
  logic              miss;
  logic              match;
  logic              accept;

  function automatic logic is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic float_eq(input logic [31:0] a, input logic [31:0] b);
    logic res;
    res = 1'b0;
    if (!is_nan(a) && !is_nan(b)) begin
      res = (a == b) || ((a[30:0] == 31'd0) && (b[30:0] == 31'd0));
    end
    return res;
  endfunction

  assign accept = start && (state_q == StIdle);
  assign busy   = (state_q != StIdle);

  always_comb begin
    key_d[0] = in_i.pos_x;
    key_d[1] = in_i.pos_y;
    key_d[2] = in_i.pos_z;
    key_d[3] = nrm_q ? in_i.norm_x : 32'd0;
    key_d[4] = nrm_q ? in_i.norm_y : 32'd0;
    key_d[5] = nrm_q ? in_i.norm_z : 32'd0;
    key_d[6] = uv_q ? in_i.tex_u : 32'd0;
    key_d[7] = uv_q ? in_i.tex_v : 32'd0;
    key_d[8] = uv_q ? in_i.tex_w : 32'd0;
  end

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < KeyLen; i++) begin
      match = match & float_eq(key_rdata[i], key_q[i]);
    end
  end

  assign miss        = (state_q == StSlot) && (slot_rdata == '0);
  assign slot_we     = (state_q == StClr) || miss;
  assign slot_waddr  = (state_q == StClr) ? clr_cnt_q : probe_q;
  assign slot_wdata  = (state_q == StClr) ? '0 : SlotW'(uc_q + 1'b1);
  assign key_we      = miss;
  assign key_raddr   = IdxW'(slot_rdata - 1'b1);
  assign remap_we    = miss || ((state_q == StCmp) && match);
  assign remap_wdata = miss ? uc_q[IdxW-1:0] : hit_idx_q;

  vwd_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start_q),
    .key_i   (key_q),
    .done_o  (hash_done),
    .hash_o  (hash_val)
  );

  vwd_ram #(.Depth(HashSlots), .Width(SlotW)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (probe_q),
    .rdata_o (slot_rdata)
  );

  vwd_ram #(.Depth(MaxVertices), .Width(KeyLen * 32)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (uc_q[IdxW-1:0]),
    .wdata_i (key_q),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  vwd_ram #(.Depth(MaxVertices), .Width(IdxW)) u_remap_ram (
    .clk_i   (clk_i),
    .we_i    (remap_we),
    .waddr_i (vs_q[IdxW-1:0]),
    .wdata_i (remap_wdata),
    .raddr_i (in_i.face_index),
    .rdata_o (remap_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StClr;
      clr_cnt_q    <= '0;
      clr_report_q <= 1'b0;
      uc_q         <= '0;
      vs_q         <= '0;
      hash_start_q <= 1'b0;
      nrm_q        <= 1'b1;
      uv_q         <= 1'b1;
      done_q       <= 1'b0;
    end else begin
      done_q       <= 1'b0;
      hash_start_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgHasNormals) begin
          nrm_q <= cfg_wdata_i;
        end else begin
          uv_q <= cfg_wdata_i;
        end
      end
      case (state_q)
        StClr: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == SlotW'(HashSlots - 1)) begin
            state_q <= StIdle;
            if (clr_report_q) begin
              done_q <= 1'b1;
              out_q  <= '0;
            end
          end
        end
        StIdle: begin
          if (accept) begin
            res_q   <= '0;
            key_q   <= key_d;
            case (in_i.cmd)
              CmdVertex: begin
                if (vs_q >= CntW'(MaxVertices)) begin
                  res_q.status <= StatusFull;
                  state_q      <= StFin;
                end else begin
                  hash_start_q <= 1'b1;
                  state_q      <= StHash;
                end
              end
              CmdFace: begin
                if (CntW'(in_i.face_index) < vs_q) begin
                  state_q <= StFace;
                end else begin
                  res_q.status <= StatusUnseen;
                  state_q      <= StFin;
                end
              end
              CmdClear: begin
                uc_q         <= '0;
                vs_q         <= '0;
                clr_cnt_q    <= '0;
                clr_report_q <= 1'b1;
                state_q      <= StClr;
              end
              default: begin
                state_q <= StFin;
              end
            endcase
          end
        end
        StHash: begin
          if (hash_done) begin
            probe_q <= hash_val;
            state_q <= StProbe;
          end
        end
        StProbe: begin
          state_q <= StSlot;
        end
        StSlot: begin
          if (miss) begin
            uc_q   <= uc_q + 1'b1;
            vs_q   <= vs_q + 1'b1;
            done_q <= 1'b1;
            out_q  <= '{vertex_index: uc_q[IdxW-1:0], is_new: 1'b1, status: StatusOk};
            state_q <= StIdle;
          end else begin
            hit_idx_q <= key_raddr;
            state_q   <= StCmp;
          end
        end
        StCmp: begin
          if (match) begin
            vs_q   <= vs_q + 1'b1;
            done_q <= 1'b1;
            out_q  <= '{vertex_index: hit_idx_q, is_new: 1'b0, status: StatusOk};
            state_q <= StIdle;
          end else begin
            // linear probing, wraps at the table size
            probe_q <= probe_q + 1'b1;
            state_q <= StProbe;
          end
        end
        StFace: begin
          done_q  <= 1'b1;
          out_q   <= '{vertex_index: remap_rdata, is_new: 1'b0, status: StatusOk};
          state_q <= StIdle;
        end
        StFin: begin
          done_q  <= 1'b1;
          out_q   <= res_q;
          state_q <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign out_o  = out_q;

endmodule
`default_nettype wire

### rtl/vwd_ram.sv
// generic single-write single-read ram with registered read data
`default_nettype none
module vwd_ram #(
  parameter int Depth = 4096,
  parameter int Width = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

### rtl/vwd_hash.sv
// iterative key hash, one key word folded in per cycle
`default_nettype none
module vwd_hash import vwd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire key_t             key_i,
  output logic                  done_o,
  output logic      [SlotW-1:0] hash_o
);

  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [8:0]  PrimeLow = 9'd403;  // prime = 2^24 + 403

  localparam logic [$clog2(KeyLen)-1:0] LastWord = $clog2(KeyLen)'(KeyLen - 1);

  logic [$clog2(KeyLen)-1:0] cnt_q;
  logic                      run_q;
  logic                      done_q;
  logic [31:0]               h_q;
  logic [31:0]               word;
  logic [31:0]               mix;
  logic [31:0]               h_d;

  always_comb begin
    word = key_i[cnt_q];
    // both zeros hash alike
    if (word[30:0] == 31'd0) begin
      word = 32'd0;
    end
    mix = h_q ^ word;
    h_d = (mix << 24) + 32'(mix * PrimeLow);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        run_q <= 1'b1;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastWord) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      h_q <= FnvBasis;
    end else if (run_q) begin
      h_q <= h_d;
    end
  end

  assign done_o = done_q;
  assign hash_o = h_q[SlotW-1:0];

endmodule
`default_nettype wire

### rtl/vwd_checker.sv
// port-level checker for the vertex weld dedup table, bound to the top level
`default_nettype none
`include "vertex_weld_dedup_table_top_assert.svh"
module vwd_checker import vwd_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o,
  input wire out_t out_o
);

  `VWD_ASSERT_NOW(a_done_not_busy, done_o, !busy, "result shown while busy")
  `VWD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command left block idle")
  `VWD_ASSERT_NEXT(a_single_result, done_o, !done_o, "result repeated")
  `VWD_ASSERT_NOW(a_new_ok, done_o && out_o.is_new, out_o.status == StatusOk, "new vertex with error")
  `VWD_ASSERT_NOW(a_err_zero, done_o && out_o.status != StatusOk, out_o.vertex_index == '0, "error result has index")

endmodule

bind vertex_weld_dedup_table_top vwd_checker u_vwd_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .out_o  (out_o)
);
`default_nettype wire

### test/vertex_weld_dedup_table_checker.sv
// checker for the vertex weld dedup table: predicts each result and compares it
`timescale 1ns / 100ps
module vertex_weld_dedup_table_checker import vwd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  input  wire logic busy,
  input  wire in_t  in_i,
  input  wire logic cfg_we_i,
  input  wire logic cfg_idx_i,
  input  wire logic cfg_wdata_i,
  input  wire logic done_o,
  input  wire out_t out_o,
  output int        pending_o,
  output int        errors_o,
  output int        checked_o,
  output int        fresh_o
);

  typedef logic [31:0] comp_t;
  typedef comp_t vkey_t [KeyLen];

  logic  use_norm, use_uv;
  vkey_t weld_keys [MaxVertices];
  logic [IdxW-1:0] orig_to_unique [MaxVertices];
  int    unique_cnt, seen_cnt;
  out_t  expected_q [$];

  assign pending_o = expected_q.size();

  function automatic logic is_nan(comp_t a);
    return a[30:23] == 8'hFF && a[22:0] != '0;
  endfunction

  function automatic logic same_float(comp_t a, comp_t b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if (a[30:0] == '0 && b[30:0] == '0) return 1'b1;
    return a == b;
  endfunction

  // equal keys always share one probe chain, so a plain scan finds the same entry
  function automatic out_t weld_result(in_t x);
    out_t  r;
    vkey_t k;
    logic  hit;
    r = '0;
    hit = 1'b0;
    case (x.cmd)
      CmdVertex: begin
        k = '{x.pos_x, x.pos_y, x.pos_z, x.norm_x, x.norm_y, x.norm_z,
              x.tex_u, x.tex_v, x.tex_w};
        if (!use_norm) begin
          k[3] = '0; k[4] = '0; k[5] = '0;
        end
        if (!use_uv) begin
          k[6] = '0; k[7] = '0; k[8] = '0;
        end
        if (seen_cnt >= MaxVertices) begin
          r.status = StatusFull;
        end else begin
          for (int u = 0; u < unique_cnt && !hit; u++) begin
            hit = 1'b1;
            for (int c = 0; c < KeyLen; c++)
              if (!same_float(weld_keys[u][c], k[c])) hit = 1'b0;
            if (hit) r.vertex_index = u[IdxW-1:0];
          end
          if (!hit) begin
            r.vertex_index = unique_cnt[IdxW-1:0];
            r.is_new = 1'b1;
            weld_keys[unique_cnt] = k;
            unique_cnt++;
          end
          orig_to_unique[seen_cnt] = r.vertex_index;
          seen_cnt++;
        end
      end
      CmdFace: begin
        if (int'(x.face_index) < seen_cnt) r.vertex_index = orig_to_unique[x.face_index];
        else r.status = StatusUnseen;
      end
      CmdClear: begin
        unique_cnt = 0;
        seen_cnt = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    errors_o++;
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    out_t w;
    if (!rst_ni) begin
      use_norm <= 1'b1;
      use_uv <= 1'b1;
      unique_cnt = 0;
      seen_cnt = 0;
      expected_q.delete();
      errors_o <= 0;
      checked_o <= 0;
      fresh_o <= 0;
    end else begin
      if (done_o) begin
        if (expected_q.size() == 0) begin
          $display("%0t result transfer with nothing expected", $time);
          errors_o++;
        end else begin
          w = expected_q.pop_front();
          if (out_o.vertex_index !== w.vertex_index)
            report("vertex_index", out_o.vertex_index, w.vertex_index);
          if (out_o.is_new !== w.is_new) report("is_new", out_o.is_new, w.is_new);
          if (out_o.status !== w.status) report("status", out_o.status, w.status);
          checked_o <= checked_o + 1;
          if (w.is_new) fresh_o <= fresh_o + 1;
        end
      end
      if (start && !busy) expected_q.insert(expected_q.size(), weld_result(in_i));
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgHasNormals) use_norm <= cfg_wdata_i;
        else use_uv <= cfg_wdata_i;
      end
    end
  end

endmodule

### test/vertex_weld_dedup_table_top_tb.sv
// testbench top for the vertex weld dedup table: stimulus, watchdog and verdict
`timescale 1ns / 100ps
module vertex_weld_dedup_table_top_tb;
  import vwd_pkg::*;

  localparam int IdleLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_d = 1'b0;
  in_t  in_d = '0;
  logic cfg_we = 1'b0;
  logic cfg_idx = 1'b0;
  logic cfg_data = 1'b0;
  logic busy, done;
  out_t out_q;
  int   pending, errs, checked, fresh;
  int   idle_cycles = 0;

  logic cur_norm = 1'b1, cur_uv = 1'b1;
  int   sent_verts = 0;
  int   burst_left = 0;
  logic quiet = 1'b0;
  in_t  key_pool [$];

  always #4 clk_i = ~clk_i;

  vertex_weld_dedup_table_top i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start_d), .busy(busy), .in_i(in_d),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_data),
    .done_o(done), .out_o(out_q)
  );

  vertex_weld_dedup_table_checker i_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start_d), .busy(busy), .in_i(in_d),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_data),
    .done_o(done), .out_o(out_q), .pending_o(pending), .errors_o(errs),
    .checked_o(checked), .fresh_o(fresh)
  );

  // clear and the reset sweep hold busy while they walk every hash slot
  always_ff @(posedge clk_i) begin
    if ((start_d && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired after %0d idle cycles", IdleLimit);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
      3: return {$urandom_range(0, 1) == 1, 31'h7F80_0000};
      4: return 32'hFFFF_FFFF;
      5: return 32'h3F80_0000;
      6: return 32'hBF80_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] flip_zero(logic [31:0] c);
    if (c[30:0] == '0 && $urandom_range(0, 1) == 1) return c ^ 32'h8000_0000;
    return c;
  endfunction

  function automatic in_t make_vertex();
    in_t x;
    x = '0;
    x.cmd = CmdVertex;
    x.face_index = 12'($urandom());
    if (key_pool.size() > 0 && $urandom_range(0, 99) < 55) begin
      x = key_pool[$urandom_range(0, key_pool.size() - 1)];
      x.pos_x = flip_zero(x.pos_x);
      x.pos_y = flip_zero(x.pos_y);
      x.norm_z = flip_zero(x.norm_z);
      x.tex_w = flip_zero(x.tex_w);
      // disabled fields must not matter
      if (!cur_norm) begin
        x.norm_x = $urandom(); x.norm_y = rand_comp(); x.norm_z = $urandom();
      end
      if (!cur_uv) begin
        x.tex_u = rand_comp(); x.tex_v = $urandom(); x.tex_w = $urandom();
      end
    end else begin
      x.pos_x = rand_comp(); x.pos_y = rand_comp(); x.pos_z = rand_comp();
      x.norm_x = rand_comp(); x.norm_y = rand_comp(); x.norm_z = rand_comp();
      x.tex_u = rand_comp(); x.tex_v = rand_comp(); x.tex_w = rand_comp();
      if (key_pool.size() < 64) key_pool.insert(key_pool.size(), x);
      else key_pool[$urandom_range(0, 63)] = x;
    end
    return x;
  endfunction

  function automatic in_t make_face(bit any);
    in_t x;
    int  hi;
    x = '0;
    x.cmd = CmdFace;
    hi = (sent_verts + 2 > 4095) ? 4095 : sent_verts + 2;
    x.face_index = any ? 12'($urandom()) : 12'($urandom_range(0, hi));
    x.pos_x = $urandom();
    return x;
  endfunction

  task automatic send(in_t x);
    int g;
    in_d <= x;
    start_d <= 1'b1;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    if (x.cmd == CmdVertex) sent_verts++;
    if (x.cmd == CmdClear) sent_verts = 0;
    if (burst_left == 0) begin
      g = quiet ? 0 : $urandom_range(0, 6);
      if (g > 0) begin
        start_d <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_cmd(logic [1:0] c);
    in_t x;
    x = '0;
    x.cmd = c;
    x.tex_v = $urandom();
    send(x);
  endtask

  task automatic drain();
    start_d <= 1'b0;
    do @(negedge clk_i); while (pending != 0 || busy);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_cfg(logic norm, logic uv);
    cfg_we <= 1'b1; cfg_idx <= CfgHasNormals; cfg_data <= norm;
    @(posedge clk_i);
    cfg_idx <= CfgHasUv; cfg_data <= uv;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    cur_norm = norm;
    cur_uv = uv;
  endtask

  task automatic random_items(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      if (i % 200 == 0) quiet = $urandom_range(0, 2) == 0;
      r = $urandom_range(0, 599);
      if (r < 2) send_cmd(CmdClear);
      else if (r < 30) send_cmd(2'd3);
      else if (r < 240) send(make_face(r < 60));
      else send(make_vertex());
    end
  endtask

  initial begin
    in_t v;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    drain();

    // directed: zeros of both signs, nan, infinity, extremes, faces, undefined command, clear
    v = '0;
    v.cmd = CmdVertex;
    send(v);
    v.pos_x = 32'h8000_0000; v.tex_w = 32'h8000_0000;
    send(v);
    v = '0; v.cmd = CmdVertex; v.pos_y = 32'h7FC0_0000;
    send(v);
    send(v);
    v.pos_y = 32'h7F80_0000;
    send(v);
    send(v);
    v = '1; v.cmd = CmdVertex;
    send(v);
    v = '0; v.cmd = CmdVertex; v.pos_z = 32'h7F7F_FFFF; v.norm_x = 32'h0000_0001;
    send(v);
    v = make_face(0); v.face_index = 12'd0; send(v);
    v.face_index = 12'd3; send(v);
    v.face_index = 12'hFFF; send(v);
    v.face_index = 12'd8; send(v);
    send_cmd(2'd3);
    send_cmd(CmdClear);
    v = make_face(0); v.face_index = 12'd0; send(v);
    v = '0; v.cmd = CmdVertex; v.pos_x = 32'h3F80_0000;
    send(v);
    drain();

    random_items(345);
    drain();
    set_cfg(1'b0, 1'b0);
    random_items(345);
    drain();
    set_cfg(1'b1, 1'b0);
    random_items(345);
    drain();
    set_cfg(1'b0, 1'b1);
    random_items(345);
    drain();
    set_cfg(1'b1, 1'b1);
    random_items(345);
    drain();

    $display("checked %0d results, %0d new vertices, over four key settings", checked, fresh);
    $display("covered signed zeros, nan and infinity keys, faces, odd commands and clears");
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (errs == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/vwd_pkg.sv
rtl/vwd_ram.sv
rtl/vwd_hash.sv
rtl/vertex_weld_dedup_table_top.sv
rtl/vwd_checker.sv
test/vertex_weld_dedup_table_checker.sv
test/vertex_weld_dedup_table_top_tb.sv
